/* design/clws_pkg.sv */
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and constants for the character-LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

  // Request codes
  localparam logic [2:0] CmdInit   = 3'd0;
  localparam logic [2:0] CmdRaw    = 3'd1;
  localparam logic [2:0] CmdChar   = 3'd2;
  localparam logic [2:0] CmdClear  = 3'd3;
  localparam logic [2:0] CmdGoto   = 3'd4;
  localparam logic [2:0] CmdNumber = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgFourBit   = 2'd0;
  localparam logic [1:0] CfgCmdHold   = 2'd1;
  localparam logic [1:0] CfgDataHold  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [9:0] CmdHoldReset  = 10'd100;
  localparam logic [9:0] DataHoldReset = 10'd10;

  // Controller command bytes
  localparam logic [7:0] LcdFunc8Bit = 8'h38;
  localparam logic [7:0] LcdFunc4Bit = 8'h28;
  localparam logic [7:0] LcdClear    = 8'h01;
  localparam logic [7:0] LcdHome     = 8'h02;
  localparam logic [7:0] LcdEntry    = 8'h06;
  localparam logic [7:0] LcdDisplay  = 8'h0F;
  localparam logic [7:0] LcdRow0     = 8'h80;
  localparam logic [7:0] LcdRow1     = 8'hC0;
  localparam logic [7:0] NibbleMask  = 8'hF0;
  localparam logic [7:0] AsciiZero   = 8'h30;

  // Message shown for a cursor target off the display
  localparam logic [7:0] OorText [16] = '{
    8'h4F, 8'h55, 8'h54, 8'h20, 8'h4F, 8'h46, 8'h20, 8'h44,
    8'h49, 8'h4D, 8'h45, 8'h4E, 8'h53, 8'h49, 8'h4F, 8'h4E
  };

  // One byte handed from the sequencer to the strobe stage
  typedef struct packed {
    logic       rs;     // register select
    logic [7:0] value;  // byte to send
    logic       whole;  // send as one strobe even in 4-bit mode
    logic       last;   // final byte of the request
  } byte_req_t;

endpackage

/* design/clws_bin2bcd.sv */
// ----------------------------------------------------------------------------
// clws_bin2bcd
// Iterative shift-add-3 converter: 16-bit binary to five BCD digits.
// ----------------------------------------------------------------------------
module clws_bin2bcd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] bin_i,
  output logic        done_o,
  output logic [19:0] bcd_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] sh_q, sh_d;
  logic [19:0] bcd_q, bcd_d;
  logic [19:0] adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                  : bcd_q[i*4 +: 4];
    end
  end

  // Step the converter one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[18:0], sh_q[15]};
      sh_d  = {sh_q[14:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* design/clws_strobe_gen.sv */
// ----------------------------------------------------------------------------
// clws_strobe_gen
// Splits bytes into one or two enable strobes and holds the output beat.
// ----------------------------------------------------------------------------
module clws_strobe_gen (
  input  logic                rst_ni,
  input  logic                clk_i,
  input  logic                four_bit_i,
  input  logic [9:0]          cmd_hold_i,
  input  logic [9:0]          data_hold_i,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  clws_pkg::byte_req_t byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_rs_o,
  output logic [7:0]          out_bus_o,
  output logic [9:0]          out_hold_o,
  output logic                out_last_o
);

  logic                busy_q, busy_d;
  logic                phase_q, phase_d;
  clws_pkg::byte_req_t req_q, req_d;
  logic                valid_q, valid_d;
  logic                rs_q, rs_d;
  logic [7:0]          bus_q, bus_d;
  logic [9:0]          hold_q, hold_d;
  logic                last_q, last_d;
  logic                slot_free, single, final_ph, emit, done;

  // Decide whether the current strobe can go and whether it ends the byte
  assign slot_free    = !valid_q || out_ready_i;
  assign single       = req_q.whole || !four_bit_i;
  assign final_ph     = single || phase_q;
  assign emit         = busy_q && slot_free;
  assign done         = emit && final_ph;
  assign byte_ready_o = !busy_q || done;

  // Build the next strobe beat
  always_comb begin
    rs_d   = rs_q;
    bus_d  = bus_q;
    hold_d = hold_q;
    last_d = last_q;
    valid_d = valid_q;
    if (emit) begin
      valid_d = 1'b1;
      rs_d    = req_q.rs;
      hold_d  = req_q.rs ? data_hold_i : cmd_hold_i;
      last_d  = req_q.last && final_ph;
      if (single) begin
        bus_d = req_q.value;
      end else if (phase_q) begin
        bus_d = {req_q.value[3:0], 4'b0000};
      end else begin
        bus_d = req_q.value & clws_pkg::NibbleMask;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Take a new byte or advance the nibble phase
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    req_d   = req_q;
    if (byte_valid_i && byte_ready_o) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      req_d   = byte_i;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (emit) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rs_q   <= rs_d;
    bus_q  <= bus_d;
    hold_q <= hold_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_rs_o    = rs_q;
  assign out_bus_o   = bus_q;
  assign out_hold_o  = hold_q;
  assign out_last_o  = last_q;

endmodule

/* design/char_lcd_write_sequencer.sv */
// Path: a request beat is registered into the sequencer state and handed to
// the strobe stage, which registers each strobe beat; a number request first
// runs the shift-add-3 converter (one bit per cycle). Throughput: one strobe
// beat per cycle while the sink is ready; requests are taken only when idle.
// Reset: 8-bit mode, command hold 100, data hold 10; no beat pending.
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns character-LCD requests into enable strobe beats with register select,
// bus value and hold time; 4-bit mode splits all but the first init byte in two.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer #(
  parameter int COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_value[7:0], row[15:8], column[23:16], number[39:24]
  input  logic [39:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Strobe stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_value[7:0], hold_ms[17:8]
  output logic [23:0] m_axis_tdata,
  // register_select[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [7:0] ColLimit = 8'(COLUMNS);

  logic [1:0]  state_q, state_d;
  logic [4:0]  idx_q, idx_d;
  logic [2:0]  cmd_q;
  logic [7:0]  bv_q, row_q, col_q;
  logic        four_bit_q;
  logic [9:0]  cmd_hold_q, data_hold_q;

  logic        in_accept;
  logic        conv_start, conv_done;
  logic [19:0] bcd;
  logic [2:0]  ndig, dpos;
  logic [3:0]  digit;
  logic [4:0]  total;
  logic        in_range;
  logic        byte_valid, byte_ready;
  clws_pkg::byte_req_t byte_req;

  logic        out_rs;
  logic [7:0]  out_bus;
  logic [9:0]  out_hold;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign conv_start    = in_accept && (s_axis_tuser == clws_pkg::CmdNumber);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q  <= 1'b0;
      cmd_hold_q  <= clws_pkg::CmdHoldReset;
      data_hold_q <= clws_pkg::DataHoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clws_pkg::CfgFourBit:  four_bit_q  <= cfg_wdata_i[0];
        clws_pkg::CfgCmdHold:  cmd_hold_q  <= cfg_wdata_i;
        clws_pkg::CfgDataHold: data_hold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the request fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= s_axis_tuser;
      bv_q  <= s_axis_tdata[7:0];
      row_q <= s_axis_tdata[15:8];
      col_q <= s_axis_tdata[23:16];
    end
  end

  clws_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (s_axis_tdata[39:24]),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  // Count significant digits, at least one
  always_comb begin
    if (bcd[19:16] != 4'd0)      ndig = 3'd5;
    else if (bcd[15:12] != 4'd0) ndig = 3'd4;
    else if (bcd[11:8] != 4'd0)  ndig = 3'd3;
    else if (bcd[7:4] != 4'd0)   ndig = 3'd2;
    else                         ndig = 3'd1;
  end

  // Pick the digit for the current step, most significant first
  assign dpos = 3'(ndig - idx_q[2:0] - 3'd1);
  always_comb begin
    case (dpos)
      3'd0:    digit = bcd[3:0];
      3'd1:    digit = bcd[7:4];
      3'd2:    digit = bcd[11:8];
      3'd3:    digit = bcd[15:12];
      default: digit = bcd[19:16];
    endcase
  end

  assign in_range = (col_q < ColLimit) && (row_q == 8'd0 || row_q == 8'd1);

  // Byte list of the current request
  always_comb begin
    total          = 5'd0;
    byte_req.rs    = 1'b0;
    byte_req.value = 8'h00;
    byte_req.whole = 1'b0;
    case (cmd_q)
      clws_pkg::CmdInit: begin
        total = 5'd5;
        case (idx_q[2:0])
          3'd0: begin
            byte_req.whole = 1'b1;
            byte_req.value = four_bit_q ? clws_pkg::LcdFunc4Bit
                                        : clws_pkg::LcdFunc8Bit;
          end
          3'd1:    byte_req.value = clws_pkg::LcdClear;
          3'd2:    byte_req.value = clws_pkg::LcdHome;
          3'd3:    byte_req.value = clws_pkg::LcdEntry;
          default: byte_req.value = clws_pkg::LcdDisplay;
        endcase
      end
      clws_pkg::CmdRaw: begin
        total          = 5'd1;
        byte_req.value = bv_q;
      end
      clws_pkg::CmdChar: begin
        total          = 5'd1;
        byte_req.rs    = 1'b1;
        byte_req.value = bv_q;
      end
      clws_pkg::CmdClear: begin
        total          = 5'd2;
        byte_req.value = (idx_q == 5'd0) ? clws_pkg::LcdClear : clws_pkg::LcdHome;
      end
      clws_pkg::CmdGoto: begin
        if (in_range) begin
          total          = 5'd1;
          byte_req.value = ((row_q == 8'd0) ? clws_pkg::LcdRow0 : clws_pkg::LcdRow1)
                           | col_q;
        end else begin
          total = 5'd17;
          if (idx_q == 5'd0) begin
            byte_req.value = clws_pkg::LcdRow0;
          end else begin
            byte_req.rs    = 1'b1;
            byte_req.value = clws_pkg::OorText[4'(idx_q - 5'd1)];
          end
        end
      end
      clws_pkg::CmdNumber: begin
        total          = {2'b00, ndig};
        byte_req.rs    = 1'b1;
        byte_req.value = clws_pkg::AsciiZero | {4'h0, digit};
      end
      default: total = 5'd0;
    endcase
    byte_req.last = (idx_q == 5'(total - 5'd1));
  end

  assign byte_valid = (state_q == StEmit) && (total != 5'd0);

  // Sequence the request: accept, convert, hand off bytes
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        idx_d = 5'd0;
        if (in_accept) begin
          state_d = conv_start ? StConv : StEmit;
        end
      end
      StConv: begin
        if (conv_done) state_d = StEmit;
      end
      StEmit: begin
        if (total == 5'd0) begin
          state_d = StIdle;
        end else if (byte_ready) begin
          idx_d = idx_q + 5'd1;
          if (byte_req.last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  clws_strobe_gen u_strobe_gen (
    .rst_ni       (rst_ni),
    .clk_i        (clk_i),
    .four_bit_i   (four_bit_q),
    .cmd_hold_i   (cmd_hold_q),
    .data_hold_i  (data_hold_q),
    .byte_valid_i (byte_valid),
    .byte_ready_o (byte_ready),
    .byte_i       (byte_req),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (out_rs),
    .out_bus_o    (out_bus),
    .out_hold_o   (out_hold),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_rs;
  assign m_axis_tdata = {6'b000000, out_hold, out_bus};

endmodule

/* tb/tb_char_lcd_write_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer
// Self-checking bench for the character-LCD write sequencer. A directed table
// walks every request kind and the edge values of each field. Several random
// phases follow, each under its own bus mode and hold times. Each request beat
// carries or is expanded into the strobe beats it should cause, and each strobe
// beat is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer;

  localparam int COLUMNS       = 16;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 65;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 21;

  // Request codes the block must ignore
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  // Register index that maps to no register
  localparam logic [1:0] CfgNone = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic [9:0] hold;
    logic       last;
  } strobe_t;

  // One directed row; typed rows carry their single strobe, the rest are predicted
  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    logic       want_rs;
    logic [7:0] want_bus;
    logic [9:0] want_hold;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the configuration registers
  logic       four_bit_mode = 1'b0;
  logic [9:0] cmd_hold      = clws_pkg::CmdHoldReset;
  logic [9:0] data_hold     = clws_pkg::DataHoldReset;

  strobe_t pending_strobes[$];
  strobe_t request_strobes[$];
  int      fail_count  = 0;
  int      quiet_cycles = 0;
  bit      no_gaps     = 1'b0;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    {clws_pkg::CmdInit,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdRaw,    8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00,
     clws_pkg::CmdHoldReset},
    {clws_pkg::CmdRaw,    8'hFF, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'hFF,
     clws_pkg::CmdHoldReset},
    {clws_pkg::CmdRaw,    8'hA5, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 8'hA5,
     clws_pkg::CmdHoldReset},
    {clws_pkg::CmdChar,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h00,
     clws_pkg::DataHoldReset},
    {clws_pkg::CmdChar,   8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF,
     clws_pkg::DataHoldReset},
    {clws_pkg::CmdChar,   8'h41, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h41,
     clws_pkg::DataHoldReset},
    {clws_pkg::CmdClear,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdGoto,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h80,
     clws_pkg::CmdHoldReset},
    {clws_pkg::CmdGoto,   8'hFF, 8'h01, 8'h0F, 16'hFFFF, 1'b1, 1'b0, 8'hCF,
     clws_pkg::CmdHoldReset},
    {clws_pkg::CmdGoto,   8'h00, 8'h00, 8'h10, 16'h0000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdGoto,   8'h00, 8'h01, 8'h10, 16'h0000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdGoto,   8'h00, 8'h02, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdGoto,   8'h00, 8'hFF, 8'hFF, 16'h0000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdNumber, 8'h00, 8'h00, 8'h00, 16'd0,    1'b1, 1'b1, 8'h30,
     clws_pkg::DataHoldReset},
    {clws_pkg::CmdNumber, 8'hFF, 8'hFF, 8'hFF, 16'd9,    1'b1, 1'b1, 8'h39,
     clws_pkg::DataHoldReset},
    {clws_pkg::CmdNumber, 8'h00, 8'h00, 8'h00, 16'd10,   1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdNumber, 8'h00, 8'h00, 8'h00, 16'd10000, 1'b0, 1'b0, 8'h00, 10'd0},
    {clws_pkg::CmdNumber, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, 1'b0, 8'h00, 10'd0},
    {CmdSpare6,           8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 8'h00, 10'd0},
    {CmdSpare7,           8'h5A, 8'h01, 8'h03, 16'h1234, 1'b0, 1'b0, 8'h00, 10'd0}
  };

  char_lcd_write_sequencer #(
    .COLUMNS(COLUMNS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all in a calm phase
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Add one strobe with the hold time of its register
  function automatic void queue_strobe(input logic rs, input logic [7:0] bus);
    strobe_t s;
    s.rs   = rs;
    s.bus  = bus;
    s.hold = rs ? data_hold : cmd_hold;
    s.last = 1'b0;
    request_strobes.push_back(s);
  endfunction

  // Split a byte into two nibble strobes in 4-bit mode
  function automatic void queue_byte(input logic rs, input logic [7:0] b);
    logic [7:0] low_nibble;
    low_nibble = b << 4;
    if (four_bit_mode) begin
      queue_strobe(rs, b & clws_pkg::NibbleMask);
      queue_strobe(rs, low_nibble & clws_pkg::NibbleMask);
    end else begin
      queue_strobe(rs, b);
    end
  endfunction

  // Expand one request into its strobe beats and append them
  function automatic void expand_request(input lcd_req_t r);
    logic [7:0]  digits [5];
    logic [15:0] value;
    int          n;
    strobe_t     s;
    request_strobes.delete();
    case (r.cmd)
      clws_pkg::CmdInit: begin
        queue_strobe(1'b0, four_bit_mode ? clws_pkg::LcdFunc4Bit : clws_pkg::LcdFunc8Bit);
        queue_byte(1'b0, clws_pkg::LcdClear);
        queue_byte(1'b0, clws_pkg::LcdHome);
        queue_byte(1'b0, clws_pkg::LcdEntry);
        queue_byte(1'b0, clws_pkg::LcdDisplay);
      end
      clws_pkg::CmdRaw:   queue_byte(1'b0, r.byte_value);
      clws_pkg::CmdChar:  queue_byte(1'b1, r.byte_value);
      clws_pkg::CmdClear: begin
        queue_byte(1'b0, clws_pkg::LcdClear);
        queue_byte(1'b0, clws_pkg::LcdHome);
      end
      clws_pkg::CmdGoto: begin
        if (r.row == 8'd0 && r.column < COLUMNS) begin
          queue_byte(1'b0, clws_pkg::LcdRow0 | r.column);
        end else if (r.row == 8'd1 && r.column < COLUMNS) begin
          queue_byte(1'b0, clws_pkg::LcdRow1 | r.column);
        end else begin
          // off the display: home, then the fixed message
          queue_byte(1'b0, clws_pkg::LcdRow0);
          for (int i = 0; i < 16; i++) queue_byte(1'b1, clws_pkg::OorText[i]);
        end
      end
      clws_pkg::CmdNumber: begin
        value = r.number;
        n = 0;
        do begin
          digits[n] = clws_pkg::AsciiZero + 8'(value % 16'd10);
          value = value / 16'd10;
          n++;
        end while (value != 16'd0);
        for (int i = n - 1; i >= 0; i--) queue_byte(1'b1, digits[i]);
      end
      default: ;
    endcase
    if (request_strobes.size() > 0) begin
      s = request_strobes.pop_back();
      s.last = 1'b1;
      request_strobes.push_back(s);
    end
    foreach (request_strobes[i]) pending_strobes.push_back(request_strobes[i]);
  endfunction

  // Drive one request beat from a falling edge; return at the falling edge after it
  task automatic send_request(input lcd_req_t r, input logic typed, input strobe_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {r.number, r.column, r.row, r.byte_value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed) pending_strobes.push_back(want);
    else expand_request(r);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every expected strobe and any ignored request in flight
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_strobes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register and track it in the shadow copy
  task automatic cfg_write(input logic [1:0] idx, input logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      clws_pkg::CfgFourBit:  four_bit_mode = data[0];
      clws_pkg::CfgCmdHold:  cmd_hold      = data;
      clws_pkg::CfgDataHold: data_hold     = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic mode, input logic [9:0] c_hold,
                                input logic [9:0] d_hold);
    cfg_write(clws_pkg::CfgFourBit, {9'($urandom), mode});
    cfg_write(clws_pkg::CfgCmdHold, c_hold);
    cfg_write(clws_pkg::CfgDataHold, d_hold);
    cfg_we_i <= 1'b0;
  endtask

  // Random request, biased toward the interesting cases of each kind
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       roll;
    r.byte_value = 8'($urandom);
    r.row        = 8'($urandom);
    r.column     = 8'($urandom);
    r.number     = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 6) r.cmd = clws_pkg::CmdInit;
    else if (roll < 20) r.cmd = clws_pkg::CmdRaw;
    else if (roll < 40) r.cmd = clws_pkg::CmdChar;
    else if (roll < 46) r.cmd = clws_pkg::CmdClear;
    else if (roll < 68) r.cmd = clws_pkg::CmdGoto;
    else if (roll < 94) r.cmd = clws_pkg::CmdNumber;
    else r.cmd = $urandom_range(0, 1) ? CmdSpare6 : CmdSpare7;
    if (r.cmd == clws_pkg::CmdGoto) begin
      case ($urandom_range(0, 3))
        0: begin
          r.row    = 8'd0;
          r.column = 8'($urandom_range(0, COLUMNS - 1));
        end
        1: begin
          r.row    = 8'd1;
          r.column = 8'($urandom_range(0, COLUMNS - 1));
        end
        2: begin
          r.row    = 8'($urandom_range(0, 1));
          r.column = 8'($urandom_range(COLUMNS, 255));
        end
        default: ;
      endcase
    end
    if (r.cmd == clws_pkg::CmdNumber) begin
      case ($urandom_range(0, 3))
        0: r.number = 16'($urandom_range(0, 9));
        1: r.number = 16'($urandom_range(10, 999));
        2: r.number = ($urandom_range(0, 1)) ? 16'hFFFF : 16'd10000;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Sink side: random stalls on the strobe stream
  initial begin : sink_ready
    int gap;
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: strobe %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Compare each strobe beat with the oldest expected one
  always @(posedge clk_i) begin : strobe_check
    strobe_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_strobes.size() == 0) begin
        $display("%0t: unexpected strobe: expected none, actual rs=%0b bus=%0h",
                 $time, m_axis_tuser, m_axis_tdata[7:0]);
        fail_count++;
      end else begin
        want = pending_strobes.pop_front();
        check_field("register_select", want.rs, m_axis_tuser);
        check_field("bus_value", want.bus, m_axis_tdata[7:0]);
        check_field("hold_ms", want.hold, m_axis_tdata[17:8]);
        check_field("last_strobe", want.last, m_axis_tlast);
        check_field("padding", 0, m_axis_tdata[23:18]);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    lcd_req_t r;
    strobe_t  want;
    int       sent;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table at reset settings
    foreach (directed_table[i]) begin
      want.rs   = directed_table[i].want_rs;
      want.bus  = directed_table[i].want_bus;
      want.hold = directed_table[i].want_hold;
      want.last = 1'b1;
      send_request(directed_table[i].req, directed_table[i].typed, want);
    end

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      case (p)
        0: apply_settings(1'b1, 10'd0, 10'd1023);
        1: apply_settings(1'b0, 10'd1023, 10'd0);
        2: apply_settings(1'b1, 10'($urandom), 10'($urandom));
        3: apply_settings(1'b0, 10'($urandom), 10'($urandom));
        4: begin
          cfg_write(CfgNone, 10'($urandom));
          apply_settings(1'b1, clws_pkg::CmdHoldReset, clws_pkg::DataHoldReset);
        end
        default: apply_settings(1'b0, 10'($urandom), 10'($urandom));
      endcase
      no_gaps = (p == 3);
      sent = 0;
      want = '0;
      while (sent < PHASE_ITEMS) begin
        r = random_request();
        send_request(r, 1'b0, want);
        if (r.cmd <= clws_pkg::CmdNumber) sent++;
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
